>>> rtl/gms_pkg.sv
// ----------------------------------------------------------------------------
// gms_pkg: shared constants and types of the gap merge sort unit
// Store geometry, stack sizing and the structs passed between sequencers.
// ----------------------------------------------------------------------------
package gms_pkg;

    localparam int DATA_W       = 32;
    localparam int STORE_DEPTH  = 64;
    localparam int MAX_ELEMENTS = 64;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int STK_DEPTH    = ADDR_W + 2;
    localparam int SP_W         = $clog2(STK_DEPTH);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } t_merge_cmd;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_ram_req;

endpackage

>>> rtl/gms_ifs.sv
// ----------------------------------------------------------------------------
// gms_ifs: valid/ready stream interfaces of the gap merge sort unit
// Input beat carries one element; output beat carries one sorted element.
// ----------------------------------------------------------------------------
interface gms_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [gms_pkg::DATA_W-1:0] value;
    logic                             last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface gms_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [gms_pkg::DATA_W-1:0] value_res;
    logic                             last_res;
    logic                             dropped;

    modport source (output valid, output value_res, output last_res, output dropped,
                    input ready);
    modport sink   (input valid, input value_res, input last_res, input dropped,
                    output ready);
endinterface

>>> rtl/gms_ram.sv
// ----------------------------------------------------------------------------
// gms_ram: generic RAM, one write port, two registered read ports
// Read data appears the cycle after the address.
// ----------------------------------------------------------------------------
module gms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> rtl/gms_merge_seq.sv
// ----------------------------------------------------------------------------
// gms_merge_seq: in-place gap merge of one range
// Shared compare-swap unit stepping pairs a gap apart, gap halved rounding up.
// ----------------------------------------------------------------------------
module gms_merge_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gms_pkg::t_merge_cmd         i_cmd,
    input  logic [gms_pkg::DATA_W-1:0]  i_rdata_a,
    input  logic [gms_pkg::DATA_W-1:0]  i_rdata_b,
    output gms_pkg::t_ram_req           o_req,
    output logic                        o_done
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_PASS = 2'd1;
    localparam logic [1:0] M_CMP  = 2'd2;
    localparam logic [1:0] M_WB   = 2'd3;

    logic [1:0]                   r_state;
    logic [gms_pkg::ADDR_W-1:0]   r_lo;
    logic [gms_pkg::ADDR_W-1:0]   r_hi;
    logic [gms_pkg::CNT_W-1:0]    r_gap;
    logic [gms_pkg::CNT_W-1:0]    r_a;
    logic [gms_pkg::CNT_W-1:0]    r_b;
    logic [gms_pkg::DATA_W-1:0]   r_x;

    logic [gms_pkg::CNT_W-1:0]    w_len;
    logic [gms_pkg::CNT_W-1:0]    w_gap0;
    logic [gms_pkg::CNT_W-1:0]    w_gap_next;
    logic                         w_in_range;
    logic                         w_swap;

    function automatic logic [gms_pkg::CNT_W-1:0] half_up(input logic [gms_pkg::CNT_W-1:0] n);
        return (n >> 1) + {{(gms_pkg::CNT_W-1){1'b0}}, n[0]};
    endfunction

    assign w_len      = {1'b0, i_cmd.hi} - {1'b0, i_cmd.lo} + gms_pkg::CNT_W'(1);
    assign w_gap0     = half_up(w_len);
    assign w_gap_next = half_up(r_gap);
    assign w_in_range = r_b <= {1'b0, r_hi};
    assign w_swap     = $signed(i_rdata_b) < $signed(i_rdata_a);

    always_comb begin
        o_req.we      = 1'b0;
        o_req.waddr   = r_a[gms_pkg::ADDR_W-1:0];
        o_req.wdata   = i_rdata_b;
        o_req.raddr_a = r_a[gms_pkg::ADDR_W-1:0];
        o_req.raddr_b = r_b[gms_pkg::ADDR_W-1:0];
        case (r_state)
            M_CMP: begin
                o_req.we = w_swap;
            end
            M_WB: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_b[gms_pkg::ADDR_W-1:0];
                o_req.wdata = r_x;
            end
            default: begin
                o_req.we = 1'b0;
            end
        endcase
    end

    assign o_done = (r_state == M_PASS) && !w_in_range && (r_gap <= gms_pkg::CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_lo    <= '0;
            r_hi    <= '0;
            r_gap   <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_x     <= '0;
        end else begin
            case (r_state)
                M_IDLE: begin
                    if (i_cmd.start) begin
                        r_lo    <= i_cmd.lo;
                        r_hi    <= i_cmd.hi;
                        r_gap   <= w_gap0;
                        r_a     <= {1'b0, i_cmd.lo};
                        r_b     <= {1'b0, i_cmd.lo} + w_gap0;
                        r_state <= M_PASS;
                    end
                end
                M_PASS: begin
                    if (w_in_range) begin
                        r_state <= M_CMP;
                    end else if (r_gap > gms_pkg::CNT_W'(1)) begin
                        r_gap <= w_gap_next;
                        r_a   <= {1'b0, r_lo};
                        r_b   <= {1'b0, r_lo} + w_gap_next;
                    end else begin
                        r_state <= M_IDLE;
                    end
                end
                M_CMP: begin
                    if (w_swap) begin
                        r_x     <= i_rdata_a;
                        r_state <= M_WB;
                    end else begin
                        r_a     <= r_a + gms_pkg::CNT_W'(1);
                        r_b     <= r_b + gms_pkg::CNT_W'(1);
                        r_state <= M_PASS;
                    end
                end
                M_WB: begin
                    r_a     <= r_a + gms_pkg::CNT_W'(1);
                    r_b     <= r_b + gms_pkg::CNT_W'(1);
                    r_state <= M_PASS;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/gms_split_seq.sv
// ----------------------------------------------------------------------------
// gms_split_seq: midpoint split sequencer of the merge sort
// Walks the split tree post-order on a small range stack, issuing merges.
// ----------------------------------------------------------------------------
module gms_split_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gms_pkg::ADDR_W-1:0] i_hi,
    input  logic                       i_merge_done,
    output gms_pkg::t_merge_cmd        o_merge,
    output logic                       o_done
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STEP  = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;

    localparam logic [1:0] PH_FRESH = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    logic [1:0]                 r_state;
    logic [gms_pkg::SP_W-1:0]   r_sp;
    logic [gms_pkg::ADDR_W-1:0] r_lo [gms_pkg::STK_DEPTH];
    logic [gms_pkg::ADDR_W-1:0] r_hi [gms_pkg::STK_DEPTH];
    logic [1:0]                 r_ph [gms_pkg::STK_DEPTH];

    logic [gms_pkg::ADDR_W-1:0] w_lo;
    logic [gms_pkg::ADDR_W-1:0] w_hi;
    logic [1:0]                 w_ph;
    logic [gms_pkg::ADDR_W:0]   w_sum;
    logic [gms_pkg::ADDR_W-1:0] w_mid;
    logic [gms_pkg::SP_W-1:0]   w_sp_up;
    logic                       w_pop;
    logic                       w_push_left;
    logic                       w_push_right;
    logic                       w_merge;

    assign w_lo    = r_lo[r_sp];
    assign w_hi    = r_hi[r_sp];
    assign w_ph    = r_ph[r_sp];
    assign w_sum   = {1'b0, w_lo} + {1'b0, w_hi};
    assign w_mid   = w_sum[gms_pkg::ADDR_W:1];
    assign w_sp_up = r_sp + gms_pkg::SP_W'(1);

    always_comb begin
        w_pop        = 1'b0;
        w_push_left  = 1'b0;
        w_push_right = 1'b0;
        w_merge      = 1'b0;
        if (r_state == S_STEP) begin
            case (w_ph)
                PH_FRESH: begin
                    if (w_lo >= w_hi) begin
                        w_pop = 1'b1;
                    end else begin
                        w_push_left = 1'b1;
                    end
                end
                PH_LEFT: begin
                    w_push_right = 1'b1;
                end
                PH_RIGHT: begin
                    w_merge = 1'b1;
                end
                default: begin
                    w_pop = 1'b1;
                end
            endcase
        end else if (r_state == S_MERGE) begin
            w_pop = i_merge_done;
        end
    end

    assign o_merge.start = w_merge;
    assign o_merge.lo    = w_lo;
    assign o_merge.hi    = w_hi;
    assign o_done        = w_pop && (r_sp == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sp    <= '0;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (w_push_left || w_push_right) begin
                        r_sp <= w_sp_up;
                    end else if (w_merge) begin
                        r_state <= S_MERGE;
                    end else if (w_pop) begin
                        if (r_sp == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sp <= r_sp - gms_pkg::SP_W'(1);
                        end
                    end
                end
                S_MERGE: begin
                    if (w_pop) begin
                        if (r_sp == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sp    <= r_sp - gms_pkg::SP_W'(1);
                            r_state <= S_STEP;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // range stack payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_lo[0] <= '0;
            r_hi[0] <= i_hi;
            r_ph[0] <= PH_FRESH;
        end else if (w_push_left) begin
            r_ph[r_sp]    <= PH_LEFT;
            r_lo[w_sp_up] <= w_lo;
            r_hi[w_sp_up] <= w_mid;
            r_ph[w_sp_up] <= PH_FRESH;
        end else if (w_push_right) begin
            r_ph[r_sp]    <= PH_RIGHT;
            r_lo[w_sp_up] <= w_mid + gms_pkg::ADDR_W'(1);
            r_hi[w_sp_up] <= w_hi;
            r_ph[w_sp_up] <= PH_FRESH;
        end
    end

endmodule

>>> rtl/gap_merge_sort_unit.sv
// ----------------------------------------------------------------------------
// gap_merge_sort_unit: collects a set of signed words, sorts, streams them out
// Merge sort with midpoint splits and in-place gap merges on a 64-entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_in_ch  : one element per beat; last closes the set and starts the sort.
//   o_out_ch : the stored elements in ascending order, last_res on the final
//              beat, dropped set on every beat of a set that overflowed.
//   Up to 64 elements are kept; later ones are dropped, a last beat still
//   closes the set.
//   Loading accepts beats back to back. Sorting runs one compare-swap unit
//   against the two read ports of the store; a swap writes the smaller word
//   back in the compare step and the larger in a writeback step after it.
//   Each output beat is read from the store, then registered; the result is
//   held in an output register until taken, and only then is the next
//   element read.
//   i_in_ch.ready is low from the last beat until the final result is taken.
//   Reset (synchronous, active low) empties the set; the store is not cleared.
// ----------------------------------------------------------------------------
module gap_merge_sort_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gms_in_if.sink    i_in_ch,
    gms_out_if.source o_out_ch
);

    localparam logic [1:0] T_LOAD = 2'd0;
    localparam logic [1:0] T_SORT = 2'd1;
    localparam logic [1:0] T_ERD  = 2'd2;
    localparam logic [1:0] T_EOUT = 2'd3;

    logic [1:0]                  r_state;
    logic [gms_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_ovf;
    logic [gms_pkg::CNT_W-1:0]   r_k;
    logic                        r_oval;
    logic                        r_rd_pend;
    logic [gms_pkg::DATA_W-1:0]  r_ovalue;
    logic                        r_olast;
    logic                        r_odrop;

    logic                        w_in_fire;
    logic                        w_out_fire;
    logic                        w_has_room;
    logic [gms_pkg::CNT_W-1:0]   w_hi_full;
    logic                        w_split_start;
    logic                        w_sort_done;
    logic                        w_merge_done;
    gms_pkg::t_merge_cmd         w_merge_cmd;
    gms_pkg::t_ram_req           w_merge_req;
    gms_pkg::t_ram_req           w_req;
    logic [gms_pkg::DATA_W-1:0]  w_rdata_a;
    logic [gms_pkg::DATA_W-1:0]  w_rdata_b;

    assign w_in_fire     = i_in_ch.valid && i_in_ch.ready;
    assign w_out_fire    = o_out_ch.valid && o_out_ch.ready;
    assign w_has_room    = r_cnt < gms_pkg::MAX_CNT;
    assign w_hi_full     = w_has_room ? r_cnt : (r_cnt - gms_pkg::CNT_W'(1));
    assign w_split_start = w_in_fire && i_in_ch.last;

    always_comb begin
        if (r_state == T_SORT) begin
            w_req = w_merge_req;
        end else begin
            w_req.we      = w_in_fire && w_has_room;
            w_req.waddr   = r_cnt[gms_pkg::ADDR_W-1:0];
            w_req.wdata   = i_in_ch.value;
            w_req.raddr_a = r_k[gms_pkg::ADDR_W-1:0];
            w_req.raddr_b = r_k[gms_pkg::ADDR_W-1:0];
        end
    end

    gms_ram #(
        .WIDTH (gms_pkg::DATA_W),
        .DEPTH (gms_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_req.we),
        .i_waddr   (w_req.waddr),
        .i_wdata   (w_req.wdata),
        .i_raddr_a (w_req.raddr_a),
        .i_raddr_b (w_req.raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    gms_split_seq u_split (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_split_start),
        .i_hi         (w_hi_full[gms_pkg::ADDR_W-1:0]),
        .i_merge_done (w_merge_done),
        .o_merge      (w_merge_cmd),
        .o_done       (w_sort_done)
    );

    gms_merge_seq u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_merge_cmd),
        .i_rdata_a (w_rdata_a),
        .i_rdata_b (w_rdata_b),
        .o_req     (w_merge_req),
        .o_done    (w_merge_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= T_LOAD;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_k       <= '0;
            r_oval    <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            case (r_state)
                T_LOAD: begin
                    if (w_in_fire) begin
                        if (w_has_room) begin
                            r_cnt <= r_cnt + gms_pkg::CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_ch.last) begin
                            r_state <= T_SORT;
                        end
                    end
                end
                T_SORT: begin
                    if (w_sort_done) begin
                        r_k     <= '0;
                        r_state <= T_ERD;
                    end
                end
                T_ERD: begin
                    // read issued this cycle, data lands next cycle
                    r_rd_pend <= 1'b1;
                    r_state   <= T_EOUT;
                end
                T_EOUT: begin
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        r_oval    <= 1'b1;
                    end else if (w_out_fire) begin
                        r_oval <= 1'b0;
                        if (r_olast) begin
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= T_LOAD;
                        end else begin
                            r_k     <= r_k + gms_pkg::CNT_W'(1);
                            r_state <= T_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= T_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == T_EOUT) && r_rd_pend) begin
            r_ovalue <= w_rdata_a;
            r_olast  <= (r_k + gms_pkg::CNT_W'(1)) == r_cnt;
            r_odrop  <= r_ovf;
        end
    end

    assign i_in_ch.ready      = (r_state == T_LOAD);
    assign o_out_ch.valid     = r_oval;
    assign o_out_ch.value_res = r_ovalue;
    assign o_out_ch.last_res  = r_olast;
    assign o_out_ch.dropped   = r_odrop;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ch.ready && o_out_ch.valid))
        else $error("input accepted while a result is pending");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= gms_pkg::MAX_CNT)
        else $error("element count beyond capacity");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_out_ch.last_res) |=> (r_cnt == '0) && !r_ovf && i_in_ch.ready)
        else $error("set not emptied after final beat");

    a_beat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> (r_k < r_cnt))
        else $error("result index outside the stored set");

endmodule
